@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define SM_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");

// consequent in the same cycle
`define SM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// consequent in the following cycle
`define SM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ rtl/stmax_pkg.sv @@
// ----------------------------------------------------------------------------
// stmax_pkg
// Shared field layout, codes and control structs of the range-max tree.
// ----------------------------------------------------------------------------
`default_nettype none

package stmax_pkg;

   localparam int POS_W       = 10;
   localparam int VAL_W       = 31;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;

   // request tdata layout, lowest bit first
   localparam int POS_LSB = 0;
   localparam int VAL_LSB = POS_LSB + POS_W;
   localparam int LO_LSB  = VAL_LSB + VAL_W;
   localparam int HI_LSB  = LO_LSB + POS_W;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic clr_en;    // write zero at the clear counter
      logic load;      // capture a new item
      logic leaf_wr;   // store the leaf value
      logic up_step;   // refresh one ancestor
      logic q_left;    // query: left edge step
      logic q_right;   // query: right edge step and climb
      logic out_load;  // move the result to the output register
   } cmd_type;

   typedef struct packed {
      logic clr_last;  // last entry of the clearing pass
      logic is_query;  // item on the input is a query
      logic pos_ok;    // write position inside the slots
      logic empty;     // range_low above range_high
      logic oor;       // range lies wholly beyond the slots
      logic lt;        // query walk not finished
      logic top;       // ancestor being refreshed is the root
      logic out_free;  // output register can take a result
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/stmax_datapath.sv @@
// ----------------------------------------------------------------------------
// stmax_datapath
// Node memory, walk registers, max unit and result register of the tree.
// ----------------------------------------------------------------------------
`default_nettype none

module stmax_datapath #(
   parameter int LEAVES = 1024
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  stmax_pkg::cmd_type                  cmd,
   output       stmax_pkg::sts_type                  sts,
   input  wire  logic [stmax_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire  logic                                req_tuser,
   output       logic                                rsp_tvalid,
   input  wire  logic                                rsp_tready,
   output       logic [stmax_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output       logic                                rsp_tuser
);

   localparam int AW = $clog2(2 * LEAVES);
   localparam int NW = $clog2(2 * LEAVES + 1);
   localparam int XW = (NW > stmax_pkg::POS_W) ? NW : stmax_pkg::POS_W;
   localparam int VW = stmax_pkg::VAL_W;
   localparam int PW = stmax_pkg::POS_W;

   logic [VW-1:0] tree_mem_ff [2 * LEAVES];

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] n_ff, n_in;
   logic [NW-1:0] l_ff, l_in;
   logic [NW-1:0] r_ff, r_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [VW-1:0] rd_data_ff;
   logic          empty_ff, empty_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_max_ff;
   logic          rsp_empty_ff;

   logic [PW-1:0] req_pos, req_lo, req_hi;
   logic [VW-1:0] req_val;
   logic [XW-1:0] lim_x, pos_x, lo_x, hi_x, hi_c_x, leaf_x, l_init_x, r_init_x;
   logic [AW-1:0] parent;
   logic [NW-1:0] r_dec;
   logic [VW-1:0] up_max;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VW-1:0] wr_data;

   assign req_pos = req_tdata[stmax_pkg::POS_LSB +: PW];
   assign req_val = req_tdata[stmax_pkg::VAL_LSB +: VW];
   assign req_lo  = req_tdata[stmax_pkg::LO_LSB +: PW];
   assign req_hi  = req_tdata[stmax_pkg::HI_LSB +: PW];

   // clamp the high end to the last slot
   assign lim_x    = XW'(LEAVES);
   assign pos_x    = XW'(req_pos);
   assign lo_x     = XW'(req_lo);
   assign hi_x     = XW'(req_hi);
   assign hi_c_x   = (hi_x >= lim_x) ? lim_x - XW'(1) : hi_x;
   assign leaf_x   = pos_x + lim_x;
   assign l_init_x = lo_x + lim_x;
   assign r_init_x = hi_c_x + lim_x + XW'(1);

   assign parent = n_ff >> 1;
   assign r_dec  = r_ff - NW'(1);
   assign up_max = (cur_ff > rd_data_ff) ? cur_ff : rd_data_ff;

   always_comb begin
      sts.clr_last = (clr_cnt_ff == AW'(2 * LEAVES - 1));
      sts.is_query = (req_tuser == stmax_pkg::FUNC_QUERY);
      sts.pos_ok   = (pos_x < lim_x);
      sts.empty    = (req_lo > req_hi);
      sts.oor      = (lo_x > hi_c_x);
      sts.lt       = (l_ff < r_ff);
      sts.top      = (parent == AW'(1));
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      rd_addr = '0;
      if (cmd.clr_en) begin
         wr_en = 1'b1;
      end
      if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_addr = n_ff;
         wr_data = cur_ff;
         rd_addr = n_ff ^ AW'(1);
      end
      if (cmd.up_step) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = up_max;
         rd_addr = parent ^ AW'(1);
      end
      if (cmd.q_left) begin
         rd_addr = l_ff[AW-1:0];
      end
      if (cmd.q_right) begin
         rd_addr = r_dec[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_mem_ff[rd_addr];
   end

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      n_in         = n_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      empty_in     = empty_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.clr_en) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
      // fold in the node read last cycle
      if (pend_ff && (rd_data_ff > acc_ff)) begin
         acc_in = rd_data_ff;
      end
      if (cmd.load) begin
         n_in     = leaf_x[AW-1:0];
         cur_in   = req_val;
         l_in     = l_init_x[NW-1:0];
         r_in     = r_init_x[NW-1:0];
         acc_in   = '0;
         empty_in = sts.empty;
      end
      if (cmd.up_step) begin
         n_in   = parent;
         cur_in = up_max;
      end
      if (cmd.q_left && l_ff[0]) begin
         l_in    = l_ff + NW'(1);
         pend_in = 1'b1;
      end
      if (cmd.q_right) begin
         pend_in = r_ff[0];
         l_in    = l_ff >> 1;
         r_in    = r_ff >> 1;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      cur_ff   <= cur_in;
      acc_ff   <= acc_in;
      empty_ff <= empty_in;
      if (cmd.out_load) begin
         rsp_max_ff   <= acc_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(stmax_pkg::RSP_TDATA_W - VW){1'b0}}, rsp_max_ff};
   assign rsp_tuser  = rsp_empty_ff;

endmodule

`default_nettype wire

@@ rtl/stmax_ctrl.sv @@
// ----------------------------------------------------------------------------
// stmax_ctrl
// Sequencer for clearing, leaf writes with ancestor refresh, and queries.
// ----------------------------------------------------------------------------
`default_nettype none

module stmax_ctrl (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                req_tvalid,
   output       logic                req_tready,
   output       stmax_pkg::cmd_type  cmd,
   input  wire  stmax_pkg::sts_type  sts
);

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_W_LEAF  = 7'b0000100,
      ST_W_UP    = 7'b0001000,
      ST_Q_LEFT  = 7'b0010000,
      ST_Q_RIGHT = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (!sts.is_query) begin
                  // drop writes beyond the last slot
                  state_in = sts.pos_ok ? ST_W_LEAF : ST_IDLE;
               end else if (sts.empty || sts.oor) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_Q_LEFT;
               end
            end
         end
         ST_W_LEAF: begin
            cmd.leaf_wr = 1'b1;
            state_in    = ST_W_UP;
         end
         ST_W_UP: begin
            cmd.up_step = 1'b1;
            if (sts.top) begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_LEFT: begin
            if (sts.lt) begin
               cmd.q_left = 1'b1;
               state_in   = ST_Q_RIGHT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_Q_RIGHT: begin
            cmd.q_right = 1'b1;
            state_in    = ST_Q_LEFT;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/segment_tree_range_max_core.sv @@
// ----------------------------------------------------------------------------
// segment_tree_range_max_core
// Max segment tree over LEAVES slots with point writes and range queries.
// ----------------------------------------------------------------------------
// Input items arrive on req_*: tuser selects write or query, tdata carries
// position, value, range_low and range_high. A write stores value at one slot
// and gives no result; a query returns the range maximum on rsp_* with the
// empty-range flag in tuser. One item is worked on at a time.
// A write stores the leaf, then refreshes one ancestor per tree level above
// the leaf up to the root; each level is one read-max-write step through the
// node memory's read and write ports.
// A query walks the tree level by level, leaves included; the left and right
// edge of the walk share the one read port, so each level takes a left step
// and a right step. Empty or out-of-slot ranges go straight to the result.
// After reset the node memory is swept to zero, entry by entry, with
// req_tready low. A stalled receiver holds the result in the output
// register; the next item is still taken, and a later query waits there
// until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segment_tree_range_max_core #(
   parameter int LEAVES = 1024
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                req_tvalid,
   output       logic                                req_tready,
   // position[9:0], value[40:10], range_low[50:41], range_high[60:51], zero pad
   input  wire  logic [stmax_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // func[0]
   input  wire  logic                                req_tuser,
   output       logic                                rsp_tvalid,
   input  wire  logic                                rsp_tready,
   // max_value[30:0], zero pad
   output       logic [stmax_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // empty_range[0]
   output       logic                                rsp_tuser
);

   stmax_pkg::cmd_type cmd;
   stmax_pkg::sts_type sts;

   stmax_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   stmax_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `SM_ASSERT_IMPL(a_clear_blocks_input, cmd.clr_en, !req_tready)
   `SM_ASSERT_IMPL(a_load_only_when_free, cmd.out_load, sts.out_free)
   `SM_ASSERT_NEXT(a_write_no_result,
      req_tvalid && req_tready && (req_tuser == stmax_pkg::FUNC_WRITE), !cmd.out_load)
   `SM_ASSERT_ALWAYS(a_single_mem_writer, $onehot0({cmd.clr_en, cmd.leaf_wr, cmd.up_step}))

endmodule

`default_nettype wire
